// ----- src/cvrp_pkg.sv -----
// Types and constants shared by the cube vertex rotate and project block.
// Depends on nothing; cvrp_ctrl, cvrp_dpath and the top level import it.
`default_nettype none

package cvrp_pkg;

   // Sine polynomial coefficients, Q2.14 arithmetic.
   localparam logic [14:0]        POLY_A  = 15'd25736;
   localparam logic [14:0]        POLY_B  = 15'd10512;
   localparam logic signed [17:0] POLY_C  = 18'sd1160;
   localparam logic [15:0]        QUARTER = 16'h4000;
   localparam logic [14:0]        ONE_Q14 = 15'h4000;

   // Smallest perspective distance that is used.
   localparam logic [15:0] P_MIN = 16'd8192;

   // Register reset values.
   localparam logic [9:0]  CX_RESET = 10'd180;
   localparam logic [9:0]  CY_RESET = 10'd188;
   localparam logic [15:0] PQ_RESET = 16'd15565;

   typedef enum logic [1:0] {
      CSR_CENTER_X    = 2'd0,
      CSR_CENTER_Y    = 2'd1,
      CSR_PERSPECTIVE = 2'd2
   } csr_idx_type;

   // Slots of the sine table.
   localparam logic [1:0] SIN_AX = 2'd0;
   localparam logic [1:0] COS_AX = 2'd1;
   localparam logic [1:0] SIN_AY = 2'd2;
   localparam logic [1:0] COS_AY = 2'd3;

   localparam logic       COORD_X     = 1'b0;
   localparam logic       COORD_Y     = 1'b1;
   localparam logic [2:0] LAST_VERTEX = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIN1,
      ST_SIN2,
      ST_SIN3,
      ST_SIN4,
      ST_ROT,
      ST_XROT,
      ST_ZROT,
      ST_VMUL,
      ST_AMUL,
      ST_DSTART,
      ST_DWAIT,
      ST_FIN,
      ST_EMIT
   } st_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SIN1,
      OP_SIN2,
      OP_SIN3,
      OP_SIN4,
      OP_ROT,
      OP_XROT,
      OP_ZROT,
      OP_VMUL,
      OP_AMUL,
      OP_DSTART,
      OP_FIN,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;
      logic [2:0] vidx;
      logic       coord;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- src/cvrp_if.sv -----
// Handshake interfaces for the request and result channels.
// Stand alone; used by the top level of the block.
`default_nettype none

interface cvrp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] rot_x_angle;
   logic signed [15:0] rot_y_angle;
   logic [15:0]        zoom_scale;

   modport source (output valid, rot_x_angle, rot_y_angle, zoom_scale, input ready);
   modport sink (input valid, rot_x_angle, rot_y_angle, zoom_scale, output ready);
endinterface

interface cvrp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         vertex_index;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic signed [15:0] depth;
   logic               last_vertex;

   modport source (output valid, vertex_index, screen_x, screen_y, depth, last_vertex,
                   input ready);
   modport sink (input valid, vertex_index, screen_x, screen_y, depth, last_vertex,
                 output ready);
endinterface

`default_nettype wire

// ----- src/cvrp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the projection step.
// Depends on nothing but the clock and reset.
`default_nettype none

module cvrp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [18:0] divisor,
   output logic             done,
   output logic [31:0]      quot,
   output logic             rem_nz
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [18:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [18:0] dsr_ff, dsr_in;
   logic [19:0] shift;
   logic [20:0] diff;
   logic        ge;

   assign shift = {rem_ff, quot_ff[31]};
   assign diff  = {1'b0, shift} - {2'b00, dsr_ff};
   assign ge    = ~diff[20];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[18:0] : shift[18:0];
         quot_in = {quot_ff[30:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign done   = done_ff;
   assign quot   = quot_ff;
   assign rem_nz = |rem_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_run_on: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != 5'd31 && !start) |=> busy_ff)
      else $error("divider stopped early");

endmodule

`default_nettype wire

// ----- src/cvrp_ctrl.sv -----
// Sequencer for the block: steps the datapath through the sines once, then
// rotation, products, division and output for each of eight corners. Uses cvrp_pkg.
`default_nettype none

module cvrp_ctrl import cvrp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   st_type     state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [2:0] vidx_ff, vidx_in;
   logic       coord_ff, coord_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= '0;
         vidx_ff  <= '0;
         coord_ff <= COORD_X;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         vidx_ff  <= vidx_in;
         coord_ff <= coord_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      vidx_in  = vidx_ff;
      coord_in = coord_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SIN1;
         ST_SIN1:   state_in = ST_SIN2;
         ST_SIN2:   state_in = ST_SIN3;
         ST_SIN3:   state_in = ST_SIN4;
         ST_SIN4: begin
            sel_in   = sel_ff + 2'd1;
            state_in = (sel_ff == COS_AY) ? ST_ROT : ST_SIN1;
         end
         ST_ROT:    state_in = ST_XROT;
         ST_XROT:   state_in = ST_ZROT;
         ST_ZROT:   state_in = ST_VMUL;
         ST_VMUL:   state_in = ST_AMUL;
         ST_AMUL:   state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DWAIT;
         ST_DWAIT:  if (status.div_done) state_in = ST_FIN;
         ST_FIN: begin
            if (coord_ff == COORD_X) begin
               coord_in = COORD_Y;
               state_in = ST_VMUL;
            end else begin
               coord_in = COORD_X;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               vidx_in  = vidx_ff + 3'd1;
               state_in = (vidx_ff == LAST_VERTEX) ? ST_IDLE : ST_ROT;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.sel   = sel_ff;
      cmd.vidx  = vidx_ff;
      cmd.coord = coord_ff;
      // No item is taken while reset is held.
      req_ready = (state_ff == ST_IDLE) && !reset;
      case (state_ff)
         ST_IDLE:   cmd.op = req_valid ? OP_CAPTURE : OP_NONE;
         ST_SIN1:   cmd.op = OP_SIN1;
         ST_SIN2:   cmd.op = OP_SIN2;
         ST_SIN3:   cmd.op = OP_SIN3;
         ST_SIN4:   cmd.op = OP_SIN4;
         ST_ROT:    cmd.op = OP_ROT;
         ST_XROT:   cmd.op = OP_XROT;
         ST_ZROT:   cmd.op = OP_ZROT;
         ST_VMUL:   cmd.op = OP_VMUL;
         ST_AMUL:   cmd.op = OP_AMUL;
         ST_DSTART: cmd.op = OP_DSTART;
         ST_FIN:    cmd.op = OP_FIN;
         ST_EMIT:   cmd.op = status.out_busy ? OP_NONE : OP_EMIT;
         default:   cmd.op = OP_NONE;
      endcase
   end

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.out_busy) |=> (state_ff == ST_EMIT))
      else $error("left output state while the output register was full");
   a_vidx_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EMIT) |=> $stable(vidx_ff))
      else $error("corner number moved outside the output state");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (vidx_ff == 3'd0 && coord_ff == COORD_X && sel_ff == SIN_AX))
      else $error("counters not rewound when idle");

endmodule

`default_nettype wire

// ----- src/cvrp_dpath.sv -----
// Datapath: configuration registers, sine evaluation, rotation, one shared
// multiplier, the divider and the output register. Uses cvrp_pkg and cvrp_div.
`default_nettype none

module cvrp_dpath import cvrp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic signed [15:0] req_rot_x_angle,
   input  wire logic signed [15:0] req_rot_y_angle,
   input  wire logic [15:0]        req_zoom_scale,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_vertex_index,
   output logic signed [15:0]      rsp_screen_x,
   output logic signed [15:0]      rsp_screen_y,
   output logic signed [15:0]      rsp_depth,
   output logic                    rsp_last_vertex
);

   // Configuration registers.
   logic [9:0]  cx_ff, cx_in;
   logic [9:0]  cy_ff, cy_in;
   logic [15:0] pq_ff, pq_in;

   // Working registers.
   logic [15:0]        ax_ff, ax_in, ay_ff, ay_in, zoom_ff, zoom_in;
   logic [14:0]        x2_ff, x2_in, t_ff, t_in;
   logic signed [15:0] sin_ff [4];
   logic signed [15:0] sin_in [4];
   logic signed [16:0] y1_ff, y1_in, z1_ff, z1_in;
   logic signed [17:0] x14_ff, x14_in;
   logic signed [15:0] z14_ff, z14_in;
   logic signed [33:0] vs_ff, vs_in;
   logic [18:0]        den_ff, den_in;
   logic signed [51:0] prod_ff, prod_in;
   logic               neg_ff, neg_in, low_nz_ff, low_nz_in;
   logic signed [15:0] scr_x_ff, scr_x_in, scr_y_ff, scr_y_in;

   // Output register.
   logic               ovalid_ff, ovalid_in;
   logic [2:0]         oidx_ff, oidx_in;
   logic signed [15:0] osx_ff, osx_in, osy_ff, osy_in, odep_ff, odep_in;
   logic               olast_ff, olast_in;

   logic [15:0]        ang;
   logic [1:0]         quad;
   logic [14:0]        sx;
   logic [15:0]        pqe;
   logic               px_pos, py_pos, pz_pos;
   logic signed [16:0] sa17, ca17, y_a, y_b, z_a, z_b;
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] prod;
   logic signed [15:0] rot_base;
   logic signed [34:0] rot_sum, rot_adj;
   logic signed [20:0] rot_q;
   logic [51:0]        mag;
   logic               div_done, div_rem_nz;
   logic [31:0]        div_quot;
   logic signed [33:0] cen, qext, pos_sum, neg_diff, scr_t;
   logic signed [15:0] scr_sat;
   logic               inexact;

   // Quarter-wave folding of the angle for the sine polynomial.
   always_comb begin
      case (cmd.sel)
         SIN_AX:  ang = ax_ff;
         COS_AX:  ang = ax_ff + QUARTER;
         SIN_AY:  ang = ay_ff;
         default: ang = ay_ff + QUARTER;
      endcase
   end
   assign quad = ang[15:14];
   assign sx   = quad[0] ? (ONE_Q14 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
   assign pqe  = (pq_ff < P_MIN) ? P_MIN : pq_ff;

   // Corner signs follow from the corner number.
   assign px_pos = cmd.vidx[0] ^ cmd.vidx[1];
   assign py_pos = cmd.vidx[1];
   assign pz_pos = cmd.vidx[2];

   assign sa17 = {sin_ff[SIN_AX][15], sin_ff[SIN_AX]};
   assign ca17 = {sin_ff[COS_AX][15], sin_ff[COS_AX]};
   assign y_a  = py_pos ? ca17 : -ca17;
   assign y_b  = pz_pos ? sa17 : -sa17;
   assign z_a  = py_pos ? sa17 : -sa17;
   assign z_b  = pz_pos ? ca17 : -ca17;

   // One shared multiplier; its operands are chosen by the current step.
   always_comb begin
      case (cmd.op)
         OP_SIN1: begin
            mul_a = {19'd0, sx};
            mul_b = {3'd0, sx};
         end
         OP_SIN2: begin
            mul_a = {19'd0, x2_ff};
            mul_b = POLY_C;
         end
         OP_SIN3: begin
            mul_a = {19'd0, x2_ff};
            mul_b = {3'd0, t_ff};
         end
         OP_SIN4: begin
            mul_a = {19'd0, sx};
            mul_b = {3'd0, t_ff};
         end
         OP_XROT: begin
            mul_a = {{17{z1_ff[16]}}, z1_ff};
            mul_b = {{2{sin_ff[SIN_AY][15]}}, sin_ff[SIN_AY]};
         end
         OP_ZROT: begin
            mul_a = {{17{z1_ff[16]}}, z1_ff};
            mul_b = {{2{sin_ff[COS_AY][15]}}, sin_ff[COS_AY]};
         end
         OP_VMUL: begin
            mul_a = (cmd.coord == COORD_Y) ? {{17{y1_ff[16]}}, y1_ff}
                                           : {{16{x14_ff[17]}}, x14_ff};
            mul_b = {2'b00, zoom_ff};
         end
         OP_AMUL: begin
            mul_a = vs_ff;
            mul_b = {2'b00, pqe};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // Rotation about Y: the corner's own x term enters shifted to Q7.28.
   always_comb begin
      if (cmd.op == OP_ZROT) begin
         rot_base = px_pos ? -sin_ff[SIN_AY] : sin_ff[SIN_AY];
      end else begin
         rot_base = px_pos ? sin_ff[COS_AY] : -sin_ff[COS_AY];
      end
   end
   assign rot_sum = $signed({{5{rot_base[15]}}, rot_base, 14'd0}) + $signed(prod[34:0]);
   assign rot_adj = rot_sum + (rot_sum[34] ? 35'sd16383 : 35'sd0);
   assign rot_q   = rot_adj[34:14];

   assign mag = prod_ff[51] ? 52'(-prod_ff) : 52'(prod_ff);

   cvrp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DSTART),
      .dividend (mag[51:20]),
      .divisor  (den_ff),
      .done     (div_done),
      .quot     (div_quot),
      .rem_nz   (div_rem_nz)
   );

   // A negative quotient with a remainder rounds towards zero, which moves the
   // result down by one only while the sum stays positive.
   assign cen      = (cmd.coord == COORD_Y) ? {24'd0, cy_ff} : {24'd0, cx_ff};
   assign qext     = {2'b00, div_quot};
   assign pos_sum  = cen + qext;
   assign neg_diff = cen - qext;
   assign inexact  = low_nz_ff | div_rem_nz;
   assign scr_t    = neg_ff ? (neg_diff - ((inexact && neg_diff > 34'sd0) ? 34'sd1 : 34'sd0))
                            : pos_sum;
   assign scr_sat  = (scr_t > 34'sd32767) ? 16'sh7FFF :
                     (scr_t < -34'sd32768) ? 16'sh8000 : scr_t[15:0];

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      pq_in     = pq_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      zoom_in   = zoom_ff;
      x2_in     = x2_ff;
      t_in      = t_ff;
      sin_in    = sin_ff;
      y1_in     = y1_ff;
      z1_in     = z1_ff;
      x14_in    = x14_ff;
      z14_in    = z14_ff;
      vs_in     = vs_ff;
      den_in    = den_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      low_nz_in = low_nz_ff;
      scr_x_in  = scr_x_ff;
      scr_y_in  = scr_y_ff;
      oidx_in   = oidx_ff;
      osx_in    = osx_ff;
      osy_in    = osy_ff;
      odep_in   = odep_ff;
      olast_in  = olast_ff;
      ovalid_in = rsp_ready ? 1'b0 : ovalid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:    cx_in = csr_wdata[9:0];
            CSR_CENTER_Y:    cy_in = csr_wdata[9:0];
            CSR_PERSPECTIVE: pq_in = csr_wdata;
            default:         ;
         endcase
      end

      case (cmd.op)
         OP_CAPTURE: begin
            ax_in   = req_rot_x_angle;
            ay_in   = req_rot_y_angle;
            zoom_in = req_zoom_scale;
         end
         OP_SIN1: x2_in = prod[28:14];
         OP_SIN2: t_in = POLY_B - prod[28:14];
         OP_SIN3: t_in = POLY_A - prod[28:14];
         OP_SIN4: begin
            sin_in[cmd.sel] = quad[1] ? -$signed({1'b0, prod[28:14]})
                                      : $signed({1'b0, prod[28:14]});
         end
         OP_ROT: begin
            y1_in = y_a - y_b;
            z1_in = z_a + z_b;
         end
         OP_XROT: x14_in = rot_q[17:0];
         OP_ZROT: begin
            z14_in = (rot_q > 21'sd32767) ? 16'sh7FFF :
                     (rot_q < -21'sd32768) ? 16'sh8000 : rot_q[15:0];
         end
         OP_VMUL: begin
            vs_in  = prod[33:0];
            den_in = {1'b0, pqe, 2'b00} + {{3{z14_ff[15]}}, z14_ff};
         end
         OP_AMUL: prod_in = prod;
         OP_DSTART: begin
            neg_in    = prod_ff[51];
            low_nz_in = |mag[19:0];
         end
         OP_FIN: begin
            if (cmd.coord == COORD_Y) begin
               scr_y_in = scr_sat;
            end else begin
               scr_x_in = scr_sat;
            end
         end
         OP_EMIT: begin
            ovalid_in = 1'b1;
            oidx_in   = cmd.vidx;
            osx_in    = scr_x_ff;
            osy_in    = scr_y_ff;
            odep_in   = z14_ff;
            olast_in  = (cmd.vidx == LAST_VERTEX);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= CX_RESET;
         cy_ff     <= CY_RESET;
         pq_ff     <= PQ_RESET;
         ovalid_ff <= 1'b0;
      end else begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         pq_ff     <= pq_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      zoom_ff   <= zoom_in;
      x2_ff     <= x2_in;
      t_ff      <= t_in;
      sin_ff    <= sin_in;
      y1_ff     <= y1_in;
      z1_ff     <= z1_in;
      x14_ff    <= x14_in;
      z14_ff    <= z14_in;
      vs_ff     <= vs_in;
      den_ff    <= den_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      low_nz_ff <= low_nz_in;
      scr_x_ff  <= scr_x_in;
      scr_y_ff  <= scr_y_in;
      oidx_ff   <= oidx_in;
      osx_ff    <= osx_in;
      osy_ff    <= osy_in;
      odep_ff   <= odep_in;
      olast_ff  <= olast_in;
   end

   assign status.div_done = div_done;
   assign status.out_busy = ovalid_ff & ~rsp_ready;

   assign rsp_valid        = ovalid_ff;
   assign rsp_vertex_index = oidx_ff;
   assign rsp_screen_x     = osx_ff;
   assign rsp_screen_y     = osy_ff;
   assign rsp_depth        = odep_ff;
   assign rsp_last_vertex  = olast_ff;

endmodule

`default_nettype wire

// ----- src/cube_vertex_rotate_project.sv -----
// Top level of the cube vertex rotate and project block.
// Depends on cvrp_pkg, cvrp_if, cvrp_ctrl, cvrp_dpath and cvrp_div.
//
//   channel   direction  carries
//   req_chan  in         rot_x_angle, rot_y_angle, zoom_scale
//   rsp_chan  out        vertex_index, screen_x, screen_y, depth, last_vertex
//   csr_*     in         center_x_px (0), center_y_px (1), perspective_q (2)
//
// Each request is accepted, the four sines are evaluated, and then each corner
// takes two passes through the radix-2 divider, one per screen coordinate,
// which sets the pace.
// Reset is synchronous and restores the register defaults.
// A full output register stalls the sequencer at the output step only;
// a new request is accepted while the final result still waits to be taken.
`default_nettype none

module cube_vertex_rotate_project import cvrp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   cvrp_req_if.sink         req_chan,
   cvrp_rsp_if.source       rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   cvrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cvrp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_rot_x_angle  (req_chan.rot_x_angle),
      .req_rot_y_angle  (req_chan.rot_y_angle),
      .req_zoom_scale   (req_chan.zoom_scale),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_vertex_index (rsp_chan.vertex_index),
      .rsp_screen_x     (rsp_chan.screen_x),
      .rsp_screen_y     (rsp_chan.screen_y),
      .rsp_depth        (rsp_chan.depth),
      .rsp_last_vertex  (rsp_chan.last_vertex)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
